// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the modular exponentiation checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define MEXP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("modular_exponentiation: assertion failed");

// Clocked assertion that also holds across reset.
`define MEXP_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("modular_exponentiation: reset assertion failed");

`endif

// ----- design/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, codes, controller/datapath interface types and the modular
// double-and-add step shared by the modular exponentiation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int CNT_WIDTH       = $clog2(DATA_WIDTH);
   localparam int TDATA_WIDTH     = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int CSR_DATA_WIDTH  = (DATA_WIDTH > 32) ? 64 : 32;
   localparam int CSR_ADDR_WIDTH  = (DATA_WIDTH > 32) ? 4 : 3;

   // register index, taken from the top address bit
   localparam logic CSR_IDX_EXPONENT = 1'b0;
   localparam logic CSR_IDX_MODULUS  = 1'b1;

   localparam logic [CNT_WIDTH-1:0] CNT_TOP = CNT_WIDTH'(DATA_WIDTH - 1);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE,
      OP_MULT,
      OP_SHIP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MULT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic bit_last;
      logic exp_zero;
      logic mod_zero;
   } status_type;

   // One step of (x * y) mod m, MSB first: (2a + ybit*x) mod m.
   // With a, x < m the sum stays below 3m, so two trial subtractions suffice.
   function automatic logic [DATA_WIDTH-1:0] mexp_step(
      input logic [DATA_WIDTH-1:0] a,
      input logic [DATA_WIDTH-1:0] x,
      input logic                  ybit,
      input logic [DATA_WIDTH-1:0] m
   );
      logic [DATA_WIDTH+1:0] t;
      logic [DATA_WIDTH+1:0] m1;
      logic [DATA_WIDTH+1:0] m2;
      logic [DATA_WIDTH+1:0] r;
      t  = {1'b0, a, 1'b0} + (ybit ? {2'b00, x} : '0);
      m1 = {2'b00, m};
      m2 = {1'b0, m, 1'b0};
      priority if (t >= m2) begin
         r = t - m2;
      end else if (t >= m1) begin
         r = t - m1;
      end else begin
         r = t;
      end
      return r[DATA_WIDTH-1:0];
   endfunction

endpackage

// ----- design/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for the square-and-multiply datapath and the request/result
// handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mexp_ctrl
   import mexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = status.mod_zero ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.op = OP_REDUCE;
            if (status.bit_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // no exponent bits left: the accumulator is final
            state_in = status.exp_zero ? ST_FINISH : ST_MULT;
         end
         ST_MULT: begin
            cmd.op = OP_MULT;
            if (status.bit_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.op   = OP_SHIP;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = (cmd.op == OP_SHIP) || (valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ----- design/mexp_dp.sv -----
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: message reduction, two bit-serial modular multipliers (multiply
// and square run side by side), exponent shifter and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mexp_dp
   import mexp_pkg::*;
(
   input  logic                  clock,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] message,
   input  logic [DATA_WIDTH-1:0] exponent,
   input  logic [DATA_WIDTH-1:0] modulus,
   output status_type            status,
   output logic [DATA_WIDTH-1:0] cipher_value,
   output logic                  modulus_error
);

   localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

   logic [DATA_WIDTH-1:0] msg_ff,  msg_in;
   logic [DATA_WIDTH-1:0] exp_ff,  exp_in;
   logic [DATA_WIDTH-1:0] base_ff, base_in;
   logic [DATA_WIDTH-1:0] acc_ff,  acc_in;
   logic [DATA_WIDTH-1:0] pa_ff,   pa_in;
   logic [DATA_WIDTH-1:0] ps_ff,   ps_in;
   logic [CNT_WIDTH-1:0]  cnt_ff,  cnt_in;
   logic                  err_ff,  err_in;
   logic [DATA_WIDTH-1:0] cipher_ff, cipher_in;
   logic                  merr_ff,   merr_in;

   logic                  reduce;
   logic                  ybit_s;
   logic [DATA_WIDTH-1:0] x_s;
   logic [DATA_WIDTH-1:0] ps_next;
   logic [DATA_WIDTH-1:0] pa_next;
   logic                  last;

   // reduction is 1 * message mod m on the squaring unit
   assign reduce  = (cmd.op == OP_REDUCE);
   assign ybit_s  = reduce ? msg_ff[cnt_ff] : base_ff[cnt_ff];
   assign x_s     = reduce ? ONE : base_ff;
   assign ps_next = mexp_step(ps_ff, x_s, ybit_s, modulus);
   assign pa_next = mexp_step(pa_ff, acc_ff, base_ff[cnt_ff], modulus);
   assign last    = (cnt_ff == '0);

   always_comb begin
      msg_in    = msg_ff;
      exp_in    = exp_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      pa_in     = pa_ff;
      ps_in     = ps_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      cipher_in = cipher_ff;
      merr_in   = merr_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            msg_in = message;
            exp_in = exponent;
            err_in = (modulus == '0);
            pa_in  = '0;
            ps_in  = '0;
            cnt_in = CNT_TOP;
         end
         OP_REDUCE: begin
            ps_in  = ps_next;
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (last) begin
               base_in = ps_next;
               acc_in  = (modulus == ONE) ? '0 : ONE;
               pa_in   = '0;
               ps_in   = '0;
               cnt_in  = CNT_TOP;
            end
         end
         OP_MULT: begin
            pa_in  = pa_next;
            ps_in  = ps_next;
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (last) begin
               base_in = ps_next;
               if (exp_ff[0]) begin
                  acc_in = pa_next;
               end
               exp_in = exp_ff >> 1;
               pa_in  = '0;
               ps_in  = '0;
               cnt_in = CNT_TOP;
            end
         end
         OP_SHIP: begin
            cipher_in = err_ff ? '0 : acc_ff;
            merr_in   = err_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      msg_ff    <= msg_in;
      exp_ff    <= exp_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      pa_ff     <= pa_in;
      ps_ff     <= ps_in;
      cnt_ff    <= cnt_in;
      err_ff    <= err_in;
      cipher_ff <= cipher_in;
      merr_ff   <= merr_in;
   end

   assign status.bit_last = last;
   assign status.exp_zero = (exp_ff == '0);
   assign status.mod_zero = (modulus == '0);

   assign cipher_value  = cipher_ff;
   assign modulus_error = merr_ff;

endmodule

// ----- design/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// RSA public-key operation: message ^ exponent mod modulus, right-to-left
// square-and-multiply with bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// One request at a time. A request is first reduced modulo the modulus, then
// each exponent bit up to the highest set one takes a check state and one
// double-and-add pass, in which multiply and square run side by side. A zero
// modulus returns zero with the error flag set, without reduction. A new
// request is taken while the previous result still waits in the output
// register.
// Exponent at byte address 0x0, modulus at 0x4, both reset to 1.
`timescale 1ns / 1ps

module modular_exponentiation
   import mexp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [TDATA_WIDTH-1:0]    req_tdata,   // [31:0] message
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [TDATA_WIDTH-1:0]    rsp_tdata,   // [31:0] cipher_value
   output logic                      rsp_tuser,   // [0] modulus_error
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [DATA_WIDTH-1:0] exponent_ff, exponent_in;
   logic [DATA_WIDTH-1:0] modulus_ff,  modulus_in;
   logic                  csr_wr;
   logic                  csr_idx;
   cmd_type               cmd;
   status_type            status;
   logic [DATA_WIDTH-1:0] cipher_value;
   logic                  modulus_error;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_WIDTH-1];

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      csr_prdata  = '0;
      unique case (csr_idx)
         CSR_IDX_EXPONENT: begin
            csr_prdata = CSR_DATA_WIDTH'(exponent_ff);
            if (csr_wr) begin
               exponent_in = csr_pwdata[DATA_WIDTH-1:0];
            end
         end
         CSR_IDX_MODULUS: begin
            csr_prdata = CSR_DATA_WIDTH'(modulus_ff);
            if (csr_wr) begin
               modulus_in = csr_pwdata[DATA_WIDTH-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= DATA_WIDTH'(1);
         modulus_ff  <= DATA_WIDTH'(1);
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   mexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mexp_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .message       (req_tdata[DATA_WIDTH-1:0]),
      .exponent      (exponent_ff),
      .modulus       (modulus_ff),
      .status        (status),
      .cipher_value  (cipher_value),
      .modulus_error (modulus_error)
   );

   assign rsp_tdata = TDATA_WIDTH'(cipher_value);
   assign rsp_tuser = modulus_error;

endmodule

// ----- design/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mexp_checker
   import mexp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [TDATA_WIDTH-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // stalled result holds
   `MEXP_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // an error result carries a zero value
   `MEXP_ASSERT(a_err_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)

   // one request in flight: ready drops after an accept
   `MEXP_ASSERT(a_one_busy, req_tvalid && req_tready |=> !req_tready)

   // nothing is offered straight out of reset
   `MEXP_ASSERT_RST(a_rst_idle, reset |=> !rsp_tvalid)

endmodule

bind modular_exponentiation mexp_checker u_checker (.*);
